>>> rtl/core/led_pkg.sv
// shared types, constants and helpers for the line editor with history
package led_pkg;

	localparam int MAX_LINE   = 32;
	localparam int HIST_DEPTH = 8;
	localparam int LW         = $clog2(MAX_LINE + 1);
	localparam int IW         = $clog2(MAX_LINE);
	localparam int HW         = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CW         = $clog2(HIST_DEPTH + 1);
	localparam int RAM_DEPTH  = HIST_DEPTH * MAX_LINE;
	localparam int AW         = $clog2(RAM_DEPTH);

	localparam logic [3:0] KEY_CHAR      = 4'd0;
	localparam logic [3:0] KEY_BACKSPACE = 4'd1;
	localparam logic [3:0] KEY_DELETE    = 4'd2;
	localparam logic [3:0] KEY_LEFT      = 4'd3;
	localparam logic [3:0] KEY_RIGHT     = 4'd4;
	localparam logic [3:0] KEY_HOME      = 4'd5;
	localparam logic [3:0] KEY_END       = 4'd6;
	localparam logic [3:0] KEY_UP        = 4'd7;
	localparam logic [3:0] KEY_DOWN      = 4'd8;
	localparam logic [3:0] KEY_ENTER     = 4'd9;
	localparam logic [3:0] KEY_INTR      = 4'd10;
	localparam logic [3:0] KEY_EOF       = 4'd11;

	localparam logic [1:0] OUT_EDIT   = 2'd0;
	localparam logic [1:0] OUT_SUBMIT = 2'd1;
	localparam logic [1:0] OUT_CANCEL = 2'd2;
	localparam logic [1:0] OUT_EOF    = 2'd3;

	typedef struct packed {
		logic [3:0] key_code;
		logic [7:0] key_char;
	} key_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic [5:0] cursor_pos;
		logic [5:0] line_length;
		logic [7:0] line_char;
		logic       char_valid;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LOAD_SETUP,
		S_LOAD,
		S_CMP,
		S_STREAM
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_EDIT,
		OP_CANCEL,
		OP_EOF,
		OP_HIST_UP,
		OP_HIST_DOWN,
		OP_RESTORE,
		OP_LOAD_SETUP,
		OP_LOAD,
		OP_LOAD_DONE,
		OP_SUBMIT_EMPTY,
		OP_SUBMIT_SETUP,
		OP_CMP,
		OP_IDX_CLR,
		OP_STREAM
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic [3:0] code;
		logic       len_zero;
		logic       hcnt_zero;
		logic       browsing;
		logic       bidx_zero;
		logic       bidx_last;
		logic       cmp_needed;
		logic       loop_done;
		logic       stream_last;
	} status_t;

	function automatic logic [HW-1:0] slot_add(input logic [HW-1:0] a, input logic [HW-1:0] b);
		logic [HW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (HW+1)'(HIST_DEPTH)) s = s - (HW+1)'(HIST_DEPTH);
		return s[HW-1:0];
	endfunction

	function automatic logic [HW-1:0] slot_dec(input logic [HW-1:0] a);
		logic [HW-1:0] s;
		if (a == '0) s = HW'(HIST_DEPTH - 1);
		else s = a - HW'(1);
		return s;
	endfunction

	// ring slot of the oldest entry
	function automatic logic [HW-1:0] slot_oldest(input logic [HW-1:0] head,
		input logic [CW-1:0] cnt);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(HIST_DEPTH) - {1'b0, cnt};
		if (s >= (CW+1)'(HIST_DEPTH)) s = s - (CW+1)'(HIST_DEPTH);
		return s[HW-1:0];
	endfunction

endpackage

>>> rtl/core/led_ram.sv
// generic single write, single read ram with registered read data
module led_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/led_dp.sv
// datapath: line and draft buffers, history ring, result register
module led_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  led_pkg::key_t   key,
	input  led_pkg::cmd_t   cmd,
	output led_pkg::status_t stat,
	output led_pkg::result_t result,
	output logic            result_valid
);

	localparam int ML = led_pkg::MAX_LINE;
	localparam int HD = led_pkg::HIST_DEPTH;
	localparam int LW = led_pkg::LW;
	localparam int IW = led_pkg::IW;
	localparam int HW = led_pkg::HW;
	localparam int CW = led_pkg::CW;
	localparam int AW = led_pkg::AW;

	led_pkg::key_t   key_q;
	logic [7:0]      line_q  [ML];
	logic [7:0]      draft_q [ML];
	logic [LW-1:0]   hlen_q  [HD];
	logic [LW-1:0]   cur_q, len_q, dlen_q, idx_q;
	logic [CW-1:0]   hcnt_q;
	logic [HW-1:0]   head_q, bidx_q, rslot_q;
	logic            brw_q, store_q, rdv_s1;
	logic [IW-1:0]   widx_s1;
	logic            res_valid_q, res_zero_q, res_cv_q, res_last_q;
	logic [1:0]      res_oc_q;
	logic [7:0]      res_char_q;

	logic [HW-1:0]   newest, load_slot;
	logic            issue, do_ins, do_del, ram_we;
	logic [LW-1:0]   del_pos;
	logic [AW-1:0]   raddr, waddr;
	logic [7:0]      rdata;
	led_pkg::op_t    op;

	assign op        = cmd.op;
	assign newest    = led_pkg::slot_dec(head_q);
	assign load_slot = led_pkg::slot_add(led_pkg::slot_oldest(head_q, hcnt_q), bidx_q);
	assign issue     = (op == led_pkg::OP_LOAD || op == led_pkg::OP_CMP) && (idx_q < len_q);
	assign raddr     = AW'(AW'(rslot_q) * AW'(ML)) + AW'(idx_q[IW-1:0]);
	assign waddr     = AW'(AW'(head_q) * AW'(ML)) + AW'(idx_q[IW-1:0]);
	assign ram_we    = (op == led_pkg::OP_STREAM) && store_q;

	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		del_pos = cur_q;
		case (key_q.key_code)
			led_pkg::KEY_CHAR: begin
				do_ins = (len_q < LW'(ML));
			end
			led_pkg::KEY_BACKSPACE: begin
				do_del  = (cur_q != '0);
				del_pos = cur_q - LW'(1);
			end
			led_pkg::KEY_DELETE, led_pkg::KEY_EOF: begin
				do_del = (cur_q < len_q);
			end
			default: begin
			end
		endcase
	end

	assign stat.code        = key_q.key_code;
	assign stat.len_zero    = (len_q == '0);
	assign stat.hcnt_zero   = (hcnt_q == '0);
	assign stat.browsing    = brw_q;
	assign stat.bidx_zero   = (bidx_q == '0);
	assign stat.bidx_last   = ((CW'(bidx_q) + CW'(1)) >= hcnt_q);
	assign stat.cmp_needed  = (hcnt_q != '0) && (hlen_q[newest] == len_q);
	assign stat.loop_done   = (idx_q == len_q) && !rdv_s1;
	assign stat.stream_last = (idx_q == len_q - LW'(1));

	led_ram #(.WIDTH(8), .DEPTH(led_pkg::RAM_DEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (line_q[idx_q[IW-1:0]]),
		.raddr (raddr),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			len_q       <= '0;
			dlen_q      <= '0;
			idx_q       <= '0;
			hcnt_q      <= '0;
			head_q      <= '0;
			bidx_q      <= '0;
			brw_q       <= 1'b0;
			store_q     <= 1'b0;
			rdv_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			rdv_s1      <= issue;
			if (issue) idx_q <= idx_q + LW'(1);
			case (op)
				led_pkg::OP_EDIT: begin
					res_valid_q <= 1'b1;
					if (do_ins) begin
						len_q <= len_q + LW'(1);
						cur_q <= cur_q + LW'(1);
						brw_q <= 1'b0;
					end else if (do_del) begin
						len_q <= len_q - LW'(1);
						cur_q <= del_pos;
						brw_q <= 1'b0;
					end else begin
						case (key_q.key_code)
							led_pkg::KEY_LEFT:  if (cur_q != '0) cur_q <= cur_q - LW'(1);
							led_pkg::KEY_RIGHT: if (cur_q < len_q) cur_q <= cur_q + LW'(1);
							led_pkg::KEY_HOME:  cur_q <= '0;
							led_pkg::KEY_END:   cur_q <= len_q;
							default: begin
							end
						endcase
					end
				end
				led_pkg::OP_CANCEL, led_pkg::OP_EOF, led_pkg::OP_SUBMIT_EMPTY: begin
					res_valid_q <= 1'b1;
					len_q  <= '0;
					cur_q  <= '0;
					brw_q  <= 1'b0;
					bidx_q <= '0;
					dlen_q <= '0;
				end
				led_pkg::OP_HIST_UP: begin
					if (!brw_q) begin
						dlen_q <= len_q;
						brw_q  <= 1'b1;
						bidx_q <= HW'(hcnt_q - CW'(1));
					end else begin
						bidx_q <= bidx_q - HW'(1);
					end
				end
				led_pkg::OP_HIST_DOWN: begin
					bidx_q <= bidx_q + HW'(1);
				end
				led_pkg::OP_RESTORE: begin
					res_valid_q <= 1'b1;
					len_q <= dlen_q;
					cur_q <= dlen_q;
					brw_q <= 1'b0;
				end
				led_pkg::OP_LOAD_SETUP: begin
					len_q <= hlen_q[load_slot];
					cur_q <= hlen_q[load_slot];
					idx_q <= '0;
				end
				led_pkg::OP_LOAD_DONE: begin
					res_valid_q <= 1'b1;
				end
				led_pkg::OP_SUBMIT_SETUP: begin
					idx_q   <= '0;
					store_q <= !stat.cmp_needed;
				end
				led_pkg::OP_CMP: begin
					if (rdv_s1 && rdata != line_q[widx_s1]) store_q <= 1'b1;
				end
				led_pkg::OP_IDX_CLR: begin
					idx_q <= '0;
				end
				led_pkg::OP_STREAM: begin
					res_valid_q <= 1'b1;
					idx_q       <= idx_q + LW'(1);
					if (stat.stream_last) begin
						if (store_q) begin
							head_q <= led_pkg::slot_add(head_q, HW'(1));
							if (hcnt_q < CW'(HD)) hcnt_q <= hcnt_q + CW'(1);
						end
						len_q  <= '0;
						cur_q  <= '0;
						brw_q  <= 1'b0;
						bidx_q <= '0;
						dlen_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// buffers and result payload
	always_ff @(posedge clk) begin
		widx_s1 <= idx_q[IW-1:0];
		case (op)
			led_pkg::OP_LATCH: begin
				key_q <= key;
			end
			led_pkg::OP_EDIT: begin
				res_oc_q   <= led_pkg::OUT_EDIT;
				res_zero_q <= 1'b0;
				res_cv_q   <= 1'b0;
				res_char_q <= '0;
				res_last_q <= 1'b1;
				if (do_ins) begin
					for (int i = 1; i < ML; i++) begin
						if (LW'(i) > cur_q) line_q[i] <= line_q[i-1];
					end
					line_q[cur_q[IW-1:0]] <= key_q.key_char;
				end else if (do_del) begin
					for (int i = 0; i < ML - 1; i++) begin
						if (LW'(i) >= del_pos) line_q[i] <= line_q[i+1];
					end
				end
			end
			led_pkg::OP_CANCEL, led_pkg::OP_EOF, led_pkg::OP_SUBMIT_EMPTY: begin
				res_oc_q   <= (op == led_pkg::OP_CANCEL) ? led_pkg::OUT_CANCEL :
				              (op == led_pkg::OP_EOF) ? led_pkg::OUT_EOF : led_pkg::OUT_SUBMIT;
				res_zero_q <= 1'b1;
				res_cv_q   <= 1'b0;
				res_char_q <= '0;
				res_last_q <= 1'b1;
			end
			led_pkg::OP_HIST_UP: begin
				if (!brw_q) begin
					for (int i = 0; i < ML; i++) draft_q[i] <= line_q[i];
				end
			end
			led_pkg::OP_RESTORE, led_pkg::OP_LOAD_DONE: begin
				res_oc_q   <= led_pkg::OUT_EDIT;
				res_zero_q <= 1'b0;
				res_cv_q   <= 1'b0;
				res_char_q <= '0;
				res_last_q <= 1'b1;
				if (op == led_pkg::OP_RESTORE) begin
					for (int i = 0; i < ML; i++) line_q[i] <= draft_q[i];
				end
			end
			led_pkg::OP_LOAD_SETUP: begin
				rslot_q <= load_slot;
			end
			led_pkg::OP_LOAD: begin
				if (rdv_s1) line_q[widx_s1] <= rdata;
			end
			led_pkg::OP_SUBMIT_SETUP: begin
				rslot_q <= newest;
			end
			led_pkg::OP_STREAM: begin
				res_oc_q   <= led_pkg::OUT_SUBMIT;
				res_zero_q <= 1'b1;
				res_cv_q   <= 1'b1;
				res_char_q <= line_q[idx_q[IW-1:0]];
				res_last_q <= stat.stream_last;
				if (stat.stream_last && store_q) hlen_q[head_q] <= len_q;
			end
			default: begin
			end
		endcase
	end

	assign result_valid       = res_valid_q;
	assign result.outcome     = res_oc_q;
	assign result.cursor_pos  = res_zero_q ? 6'd0 : 6'(cur_q);
	assign result.line_length = res_zero_q ? 6'd0 : 6'(len_q);
	assign result.line_char   = res_char_q;
	assign result.char_valid  = res_cv_q;
	assign result.last        = res_last_q;

	a_cur_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q) else $error("cursor beyond line end");
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(ML)) else $error("line length overflow");
	a_hcnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= CW'(HD)) else $error("history count overflow");
	a_rd_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> ($past(op) == led_pkg::OP_LOAD || $past(op) == led_pkg::OP_CMP))
		else $error("history read outside load or compare");

endmodule

>>> rtl/core/led_ctrl.sv
// controller: sequences each key word through the datapath
module led_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  led_pkg::status_t stat,
	output led_pkg::cmd_t    cmd,
	output logic             busy
);

	led_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= led_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			led_pkg::S_IDLE: begin
				if (start) state_d = led_pkg::S_DECODE;
			end
			led_pkg::S_DECODE: begin
				state_d = led_pkg::S_IDLE;
				case (stat.code)
					led_pkg::KEY_UP: begin
						if (!(stat.hcnt_zero || (stat.browsing && stat.bidx_zero)))
							state_d = led_pkg::S_LOAD_SETUP;
					end
					led_pkg::KEY_DOWN: begin
						if (!stat.hcnt_zero && stat.browsing && !stat.bidx_last)
							state_d = led_pkg::S_LOAD_SETUP;
					end
					led_pkg::KEY_ENTER: begin
						if (!stat.len_zero)
							state_d = stat.cmp_needed ? led_pkg::S_CMP : led_pkg::S_STREAM;
					end
					default: begin
					end
				endcase
			end
			led_pkg::S_LOAD_SETUP: state_d = led_pkg::S_LOAD;
			led_pkg::S_LOAD: begin
				if (stat.loop_done) state_d = led_pkg::S_IDLE;
			end
			led_pkg::S_CMP: begin
				if (stat.loop_done) state_d = led_pkg::S_STREAM;
			end
			led_pkg::S_STREAM: begin
				if (stat.stream_last) state_d = led_pkg::S_IDLE;
			end
			default: state_d = led_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = led_pkg::OP_NONE;
		case (state_q)
			led_pkg::S_IDLE: begin
				if (start) cmd.op = led_pkg::OP_LATCH;
			end
			led_pkg::S_DECODE: begin
				case (stat.code)
					led_pkg::KEY_UP: begin
						if (stat.hcnt_zero || (stat.browsing && stat.bidx_zero))
							cmd.op = led_pkg::OP_EDIT;
						else cmd.op = led_pkg::OP_HIST_UP;
					end
					led_pkg::KEY_DOWN: begin
						if (stat.hcnt_zero || !stat.browsing) cmd.op = led_pkg::OP_EDIT;
						else if (stat.bidx_last) cmd.op = led_pkg::OP_RESTORE;
						else cmd.op = led_pkg::OP_HIST_DOWN;
					end
					led_pkg::KEY_ENTER: begin
						cmd.op = stat.len_zero ? led_pkg::OP_SUBMIT_EMPTY : led_pkg::OP_SUBMIT_SETUP;
					end
					led_pkg::KEY_INTR: cmd.op = led_pkg::OP_CANCEL;
					led_pkg::KEY_EOF: begin
						cmd.op = stat.len_zero ? led_pkg::OP_EOF : led_pkg::OP_EDIT;
					end
					default: cmd.op = led_pkg::OP_EDIT;
				endcase
			end
			led_pkg::S_LOAD_SETUP: cmd.op = led_pkg::OP_LOAD_SETUP;
			led_pkg::S_LOAD: begin
				cmd.op = stat.loop_done ? led_pkg::OP_LOAD_DONE : led_pkg::OP_LOAD;
			end
			led_pkg::S_CMP: begin
				cmd.op = stat.loop_done ? led_pkg::OP_IDX_CLR : led_pkg::OP_CMP;
			end
			led_pkg::S_STREAM: cmd.op = led_pkg::OP_STREAM;
			default: cmd.op = led_pkg::OP_NONE;
		endcase
	end

	assign busy = (state_q != led_pkg::S_IDLE);

	a_latch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == led_pkg::OP_LATCH) |=> (state_q == led_pkg::S_DECODE))
		else $error("accepted word not decoded");
	a_stream_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == led_pkg::S_STREAM && stat.stream_last) |=> !busy)
		else $error("submit did not finish");

endmodule

>>> rtl/core/line_editor_with_history.sv
// top level: line editor with history ring
// Key words are taken on start while busy is low; each produces one or more
// result words on result, one per cycle with result_valid high, and the receiver
// cannot stall them. An editing key holds busy only while it is decoded, and its result
// word follows in the next cycle. A history recall copies the entry from the history
// RAM one character a cycle and holds busy until the whole entry is copied.
// Enter streams one character per cycle, preceded by a compare pass against the
// newest entry (one RAM read a cycle) when the lengths match. The single read port
// of the history RAM sets the recall and compare rates.
module line_editor_with_history (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  led_pkg::key_t    key,
	output logic             busy,
	output led_pkg::result_t result,
	output logic             result_valid
);

	led_pkg::cmd_t    cmd;
	led_pkg::status_t stat;

	led_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	led_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.key          (key),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
